// ===== hdl/mcss_pkg.sv =====
// Shared types for the minimum covering subset search block.
// Opcodes, configuration register indexes and the controller/datapath link.
// No dependencies.
package mcss_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_REQ = 2'd0,
    OP_LOAD_SUP = 2'd1,
    OP_START    = 2'd2
  } opcode_t;

  typedef enum logic [0:0] {
    REG_NUM_VITAMINS = 1'b0,
    REG_NUM_FEEDS    = 1'b1
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // write requirement table
    logic load_sup;   // write supply table
    logic init;       // size 1, first subset, first column
    logic rewind;     // member counter back to zero
    logic walk;       // step to next member of the subset
    logic col_next;   // next column, same subset
    logic comb_next;  // next subset of same size
    logic size_next;  // first subset of next size
    logic emit_hit;   // load one found result into the output register
    logic emit_miss;  // load the not-found result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic nf_zero;
    logic nv_zero;
    logic last_member;
    logic col_ok;
    logic last_col;
    logic has_next;
    logic last_size;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/mcss_dp.sv =====
// Datapath: configuration registers, requirement/supply memories, subset
// index registers, column accumulator and output register.
// Depends on mcss_pkg.
module mcss_dp #(
  parameter int MAX_VITAMINS = 32,
  parameter int MAX_FEEDS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcss_pkg::cmd_t     cmd,
  output mcss_pkg::stat_t    stat,
  input  logic               cfg_valid,
  input  logic [0:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic [4:0]         in_vitamin_index,
  input  logic [3:0]         in_feed_index,
  input  logic [9:0]         in_amount,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_found,
  output logic [4:0]         out_subset_size,
  output logic [4:0]         out_feed_number,
  output logic               out_last
);

  localparam int VIW    = (MAX_VITAMINS > 1) ? $clog2(MAX_VITAMINS) : 1;
  localparam int VCW    = $clog2(MAX_VITAMINS + 1);
  localparam int FIW    = (MAX_FEEDS > 1) ? $clog2(MAX_FEEDS) : 1;
  localparam int KW     = $clog2(MAX_FEEDS + 1);
  localparam int SDEPTH = MAX_FEEDS * MAX_VITAMINS;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int SUMW   = 10 + KW;

  logic [5:0]      nv_r;
  logic [4:0]      nf_r;
  logic [VCW-1:0]  nv_eff;
  logic [KW-1:0]   nf_eff;

  logic [9:0]      req_mem [MAX_VITAMINS];
  logic [9:0]      sup_mem [SDEPTH];
  logic [9:0]      req_q;
  logic [9:0]      sup_q;

  logic [KW-1:0]   k_r, k_nxt;
  logic [FIW-1:0]  i_r, i_nxt;
  logic [VIW-1:0]  v_r, v_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [FIW-1:0]  sel_r  [MAX_FEEDS];
  logic [FIW-1:0]  sel_nxt[MAX_FEEDS];
  logic [FIW-1:0]  scan_r [MAX_FEEDS];
  logic [FIW-1:0]  scan_nxt[MAX_FEEDS];
  logic [FIW-1:0]  adv    [MAX_FEEDS];

  logic [MAX_FEEDS-1:0] can;
  logic [FIW-1:0]  pos;
  logic [FIW-1:0]  sel_pos;
  logic [FIW-1:0]  feed_cur;
  logic [SAW-1:0]  sup_raddr;
  logic [SAW-1:0]  sup_waddr;
  logic [6:0]      vi7;
  logic [4:0]      fi5;
  logic [VIW-1:0]  vi_w;
  logic [FIW-1:0]  fi_w;
  logic            vi_ok;
  logic            fi_ok;
  logic [SUMW-1:0] col_total;

  logic            out_valid_r;
  logic            out_found_r;
  logic [4:0]      out_size_r;
  logic [4:0]      out_feed_r;
  logic            out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 6'd1;
      nf_r <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mcss_pkg::REG_NUM_VITAMINS: nv_r <= cfg_data;
        mcss_pkg::REG_NUM_FEEDS:    nf_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign nv_eff = ({1'b0, nv_r} > 7'(MAX_VITAMINS)) ? VCW'(MAX_VITAMINS) : VCW'(nv_r);
  assign nf_eff = ({1'b0, nf_r} > 6'(MAX_FEEDS)) ? KW'(MAX_FEEDS) : KW'(nf_r);

  // table loads
  assign vi7   = {2'b00, in_vitamin_index};
  assign fi5   = {1'b0, in_feed_index};
  assign vi_w  = vi7[VIW-1:0];
  assign fi_w  = fi5[FIW-1:0];
  assign vi_ok = vi7 < 7'(MAX_VITAMINS);
  assign fi_ok = fi5 < 5'(MAX_FEEDS);

  // member 0 comes straight from the subset, later members from the shifted copy
  assign feed_cur  = (i_r == '0) ? sel_r[0] : scan_r[0];
  assign sup_raddr = SAW'(feed_cur) * SAW'(MAX_VITAMINS) + SAW'(v_r);
  assign sup_waddr = SAW'(fi_w) * SAW'(MAX_VITAMINS) + SAW'(vi_w);

  always_ff @(posedge clk) begin
    if (cmd.load_req && vi_ok) begin
      req_mem[vi_w] <= in_amount;
    end
    req_q <= req_mem[v_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sup && vi_ok && fi_ok) begin
      sup_mem[sup_waddr] <= in_amount;
    end
    sup_q <= sup_mem[sup_raddr];
  end

  // next subset of the same size: rightmost member that can still move up
  always_comb begin
    pos = '0;
    for (int p = 0; p < MAX_FEEDS; p++) begin
      can[p] = ((KW+1)'(p) < (KW+1)'(k_r)) &&
               ((KW+1)'(sel_r[p]) + (KW+1)'(k_r) < (KW+1)'(nf_eff) + (KW+1)'(p));
      if (can[p]) begin
        pos = FIW'(p);
      end
    end
  end

  assign sel_pos = sel_r[pos];

  always_comb begin
    for (int j = 0; j < MAX_FEEDS; j++) begin
      if (FIW'(j) < pos) begin
        adv[j] = sel_r[j];
      end else begin
        adv[j] = sel_pos + FIW'(j) - pos + FIW'(1);
      end
    end
  end

  assign col_total = sum_r + SUMW'(sup_q);

  always_comb begin
    k_nxt   = k_r;
    i_nxt   = i_r;
    v_nxt   = v_r;
    sum_nxt = sum_r;
    for (int j = 0; j < MAX_FEEDS; j++) begin
      sel_nxt[j]  = sel_r[j];
      scan_nxt[j] = scan_r[j];
    end

    if (cmd.walk) begin
      i_nxt   = i_r + FIW'(1);
      sum_nxt = (i_r == '0) ? '0 : col_total;
      for (int j = 0; j < MAX_FEEDS - 1; j++) begin
        scan_nxt[j] = (i_r == '0) ? sel_r[j+1] : scan_r[j+1];
      end
    end
    if (cmd.rewind) begin
      i_nxt = '0;
    end
    if (cmd.col_next) begin
      v_nxt = v_r + VIW'(1);
    end
    if (cmd.comb_next) begin
      v_nxt = '0;
      for (int j = 0; j < MAX_FEEDS; j++) begin
        sel_nxt[j] = adv[j];
      end
    end
    if (cmd.init || cmd.size_next) begin
      v_nxt = '0;
      k_nxt = cmd.init ? KW'(1) : k_r + KW'(1);
      for (int j = 0; j < MAX_FEEDS; j++) begin
        sel_nxt[j] = FIW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    v_r   <= v_nxt;
    sum_r <= sum_nxt;
    for (int j = 0; j < MAX_FEEDS; j++) begin
      sel_r[j]  <= sel_nxt[j];
      scan_r[j] <= scan_nxt[j];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_hit || cmd.emit_miss) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      out_found_r <= 1'b1;
      out_size_r  <= 5'(k_r);
      out_feed_r  <= 5'(feed_cur) + 5'd1;
      out_last_r  <= stat.last_member;
    end else if (cmd.emit_miss) begin
      out_found_r <= 1'b0;
      out_size_r  <= 5'd0;
      out_feed_r  <= 5'd0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_subset_size = out_size_r;
  assign out_feed_number = out_feed_r;
  assign out_last        = out_last_r;

  always_comb begin
    stat.nf_zero     = (nf_eff == '0);
    stat.nv_zero     = (nv_eff == '0);
    stat.last_member = (KW'(i_r) + KW'(1) == k_r);
    stat.col_ok      = (col_total >= SUMW'(req_q));
    stat.last_col    = (VCW'(v_r) + VCW'(1) == nv_eff);
    stat.has_next    = |can;
    stat.last_size   = (k_r == nf_eff);
    stat.out_free    = !out_valid_r || out_ready;
  end

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> KW'(i_r) < k_r)
    else $error("member counter ran past subset size");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (k_r != '0) && (k_r <= nf_eff))
    else $error("subset size outside rows in use");

  a_hit_feed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_feed_r != 5'd0) && (out_feed_r <= 5'(nf_eff)))
    else $error("reported row outside rows in use");

endmodule

// ===== hdl/mcss_ctrl.sv =====
// Controller: input decode and search sequencing state machine.
// Drives datapath commands, reads datapath status. Depends on mcss_pkg.
module mcss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  output mcss_pkg::cmd_t   cmd,
  input  mcss_pkg::stat_t  stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_SUM   = 6'b000100,
    S_CHECK = 6'b001000,
    S_EMIT  = 6'b010000,
    S_MISS  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_opcode)
            mcss_pkg::OP_LOAD_REQ: cmd.load_req = 1'b1;
            mcss_pkg::OP_LOAD_SUP: cmd.load_sup = 1'b1;
            mcss_pkg::OP_START:    state_nxt = S_INIT;
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        cmd.rewind = 1'b1;
        if (stat.nf_zero) begin
          state_nxt = S_MISS;
        end else if (stat.nv_zero) begin
          state_nxt = S_EMIT;   // no columns: first single row covers
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.walk = 1'b1;
        if (stat.last_member) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.rewind = 1'b1;
        if (stat.col_ok && stat.last_col) begin
          state_nxt = S_EMIT;
        end else if (stat.col_ok) begin
          cmd.col_next = 1'b1;
          state_nxt    = S_SUM;
        end else if (stat.has_next) begin
          cmd.comb_next = 1'b1;
          state_nxt     = S_SUM;
        end else if (!stat.last_size) begin
          cmd.size_next = 1'b1;
          state_nxt     = S_SUM;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_hit = 1'b1;
          cmd.walk     = 1'b1;
          if (stat.last_member) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_opcode == mcss_pkg::OP_START)) |=> (state_r == S_INIT))
    else $error("start item did not begin a search");

  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && ($past(state_r) != S_EMIT)) |->
      (($past(state_r) == S_CHECK) || ($past(state_r) == S_INIT)))
    else $error("result run started without a covering subset");

  a_check_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_SUM))
    else $error("column compare without a summed column");

endmodule

// ===== hdl/min_covering_subset_search.sv =====
// Top level of the minimum covering subset search block.
// Instantiates mcss_ctrl and mcss_dp; depends on mcss_pkg.
//
// channel | direction | ports
// --------+-----------+------------------------------------------------------
// in      | sink      | in_valid/in_ready, opcode, vitamin_index, feed_index, amount
// out     | source    | out_valid/out_ready, found, subset_size, feed_number, last
// cfg     | sink      | cfg_valid/cfg_ready, cfg_index, cfg_data (always ready)
//
// Load items are accepted back to back. A start item runs the setup state, then for
// each subset tried and each column checked reads k supplies through the single
// supply-table read port and compares, stopping at the first failing column, then
// emits one result per cycle while the output register is free. in_ready is low
// from start until the last result is in the output register; results wait there
// while out_ready is low. Reset (rst_n low, synchronous) clears control state and
// sets num_vitamins and num_feeds to 1; tables hold garbage until loaded.
module min_covering_subset_search #(
  parameter int MAX_VITAMINS = 32,
  parameter int MAX_FEEDS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_vitamin_index,
  input  logic [3:0] in_feed_index,
  input  logic [9:0] in_amount,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [4:0] out_subset_size,
  output logic [4:0] out_feed_number,
  output logic       out_last
);

  mcss_pkg::cmd_t  cmd;
  mcss_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  mcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mcss_dp #(
    .MAX_VITAMINS (MAX_VITAMINS),
    .MAX_FEEDS    (MAX_FEEDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_vitamin_index (in_vitamin_index),
    .in_feed_index    (in_feed_index),
    .in_amount        (in_amount),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_subset_size  (out_subset_size),
    .out_feed_number  (out_feed_number),
    .out_last         (out_last)
  );

endmodule
